// ===== hw/rtl/rrn_pkg.sv =====
package rrn_pkg;

  // CORDIC iteration count, capped at 24; angle entries past the 15th are zero.
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int STEP_W       = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

  // Datapath widths: light minus position, scaled CORDIC vector, wheel drive.
  localparam int DXY_W  = 18;
  localparam int CORD_W = 28;
  localparam int DRV_W  = 18;

  // Navigation modes.
  localparam logic [2:0] MODE_SEEK     = 3'd0;
  localparam logic [2:0] MODE_AVOID    = 3'd1;
  localparam logic [2:0] MODE_TURN_L   = 3'd2;
  localparam logic [2:0] MODE_TURN_R   = 3'd3;
  localparam logic [2:0] MODE_FOLLOW_L = 3'd4;
  localparam logic [2:0] MODE_FOLLOW_R = 3'd5;

  // Thresholds and drive levels in Q2.14.
  localparam logic signed [15:0] TH_095 = 16'sd15565;
  localparam logic signed [15:0] TH_08  = 16'sd13107;
  localparam logic signed [15:0] TH_07  = 16'sd11469;
  localparam logic signed [15:0] TH_06  = 16'sd9830;
  localparam logic signed [15:0] TH_05  = 16'sd8192;
  localparam logic signed [15:0] TH_04  = 16'sd6554;
  localparam logic signed [15:0] TH_03  = 16'sd4915;
  localparam logic signed [15:0] TH_02  = 16'sd3277;
  localparam logic signed [15:0] TH_015 = 16'sd2458;
  localparam logic signed [15:0] TH_005 = 16'sd819;
  localparam logic signed [15:0] ONE_Q  = 16'sd16384;

  localparam logic [7:0] AVOID_TICKS = 8'd10;
  localparam logic [7:0] TURN_TICKS  = 8'd20;

  typedef struct packed {
    logic signed [15:0] range_left;
    logic signed [15:0] range_mid;
    logic signed [15:0] range_right;
    logic signed [15:0] light_level;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] heading_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] wheel_left;
    logic signed [15:0] wheel_right;
    logic        [2:0]  mode;
  } out_item_t;

  // Mode update handed from the transition logic to the sequencer.
  typedef struct packed {
    logic [2:0]              mode;
    logic [7:0]              ticks;
    logic                    seek;
    logic signed [DRV_W-1:0] wl;
    logic signed [DRV_W-1:0] wr;
  } mode_upd_t;

  // Rounded arctangent of 2^-i in binary angle units.
  function automatic logic [15:0] atan_entry(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'd8192;
      5'd1:    v = 16'd4836;
      5'd2:    v = 16'd2555;
      5'd3:    v = 16'd1297;
      5'd4:    v = 16'd651;
      5'd5:    v = 16'd326;
      5'd6:    v = 16'd163;
      5'd7:    v = 16'd81;
      5'd8:    v = 16'd41;
      5'd9:    v = 16'd20;
      5'd10:   v = 16'd10;
      5'd11:   v = 16'd5;
      5'd12:   v = 16'd3;
      5'd13:   v = 16'd1;
      5'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/rrn_mode.sv =====
module rrn_mode (
  input  logic [2:0]             nav_mode,
  input  logic [7:0]             mode_ticks,
  input  logic signed [15:0]     sl,
  input  logic signed [15:0]     sm,
  input  logic signed [15:0]     sr,
  output rrn_pkg::mode_upd_t     upd
);
  import rrn_pkg::*;

  logic [7:0] ticks_inc;
  logic [2:0] m;
  logic       clr;

  // Tick timer saturates instead of wrapping.
  assign ticks_inc = (mode_ticks == 8'hFF) ? 8'hFF : mode_ticks + 8'd1;

  // Threshold transitions; the emergency rule overrides every mode.
  always_comb begin
    m   = nav_mode;
    clr = 1'b0;
    priority if (sm > TH_095 || sl > TH_095 || sr > TH_095) begin
      m   = MODE_AVOID;
      clr = 1'b1;
    end else if (nav_mode == MODE_AVOID) begin
      if (ticks_inc > AVOID_TICKS) begin
        m   = (sl > sr) ? MODE_TURN_R : MODE_TURN_L;
        clr = 1'b1;
      end
    end else if (nav_mode == MODE_TURN_L || nav_mode == MODE_TURN_R) begin
      if (ticks_inc > TURN_TICKS && sm < TH_04) begin
        m   = MODE_SEEK;
        clr = 1'b1;
      end
    end else if (nav_mode == MODE_FOLLOW_L) begin
      if (sl < TH_015 || sm > TH_06) begin
        m   = MODE_SEEK;
        clr = 1'b1;
      end
    end else if (nav_mode == MODE_FOLLOW_R) begin
      if (sr < TH_015 || sm > TH_06) begin
        m   = MODE_SEEK;
        clr = 1'b1;
      end
    end else begin
      clr = 1'b1;
      priority if (sm > TH_06) begin
        m = MODE_AVOID;
      end else if (sl > TH_05 && sr < TH_03) begin
        m = MODE_TURN_R;
      end else if (sr > TH_05 && sl < TH_03) begin
        m = MODE_TURN_L;
      end else if (sl > TH_03 && sl < TH_07) begin
        m = MODE_FOLLOW_L;
      end else if (sr > TH_03 && sr < TH_07) begin
        m = MODE_FOLLOW_R;
      end else begin
        m   = MODE_SEEK;
        clr = 1'b0;
      end
    end
  end

  // Fixed wheel drives for every mode but seek.
  always_comb begin
    upd.mode  = m;
    upd.ticks = clr ? 8'd0 : ticks_inc;
    upd.seek  = 1'b0;
    upd.wl    = DRV_W'(TH_07);
    upd.wr    = DRV_W'(TH_07);
    unique case (m)
      MODE_AVOID: begin
        upd.wl = -DRV_W'(TH_08);
        upd.wr = -DRV_W'(TH_08);
      end
      MODE_TURN_L: begin
        upd.wl = -DRV_W'(TH_05);
        upd.wr = DRV_W'(TH_05);
      end
      MODE_TURN_R: begin
        upd.wl = DRV_W'(TH_05);
        upd.wr = -DRV_W'(TH_05);
      end
      MODE_FOLLOW_L: begin
        if (sl > TH_05) begin
          upd.wl = DRV_W'(TH_08);
          upd.wr = DRV_W'(TH_05);
        end else if (sl < TH_02) begin
          upd.wl = DRV_W'(TH_05);
          upd.wr = DRV_W'(TH_08);
        end else begin
          upd.wl = DRV_W'(TH_06);
          upd.wr = DRV_W'(TH_07);
        end
      end
      MODE_FOLLOW_R: begin
        if (sr > TH_05) begin
          upd.wl = DRV_W'(TH_05);
          upd.wr = DRV_W'(TH_08);
        end else if (sr < TH_02) begin
          upd.wl = DRV_W'(TH_08);
          upd.wr = DRV_W'(TH_05);
        end else begin
          upd.wl = DRV_W'(TH_07);
          upd.wr = DRV_W'(TH_06);
        end
      end
      default: begin
        upd.seek = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rrn_cordic.sv =====
module rrn_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [rrn_pkg::DXY_W-1:0] dx,
  input  logic signed [rrn_pkg::DXY_W-1:0] dy,
  output logic                             busy,
  output logic                             done,
  output logic [15:0]                      angle
);
  import rrn_pkg::*;

  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic [15:0]              z;
  logic [STEP_W-1:0]        cnt;
  logic signed [CORD_W-1:0] x0;
  logic signed [CORD_W-1:0] y0;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic [15:0]              atan_v;

  // Vector scaled by 256 before the rotations.
  assign x0 = {{(CORD_W-DXY_W-8){dx[DXY_W-1]}}, dx, 8'b0};
  assign y0 = {{(CORD_W-DXY_W-8){dy[DXY_W-1]}}, dy, 8'b0};

  // One vectoring step per cycle through the shared shifter and adders.
  assign xs     = x >>> cnt;
  assign ys     = y >>> cnt;
  assign atan_v = atan_entry(5'(cnt));
  assign angle  = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (dx == '0 && dy == '0) begin
          // Zero vector: the angle is zero.
          z    <= 16'd0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x0 < 0) begin
            x <= -x0;
            y <= -y0;
            z <= 16'd32768;
          end else begin
            x <= x0;
            y <= y0;
            z <= 16'd0;
          end
        end
      end else if (busy) begin
        if (!y[CORD_W-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_v;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_v;
        end
        if (cnt == STEP_W'(CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/reactive_robot_navigation_fsm.sv =====
// Reactive robot navigation controller: one control tick per input transaction.
// The input channel (in_valid/in_ready/in_item) carries the three obstacle
// sensors, the light level, the position and the heading. Each accepted
// transaction yields exactly one result transaction on out_valid/out_ready/
// out_item: the new navigation mode and the two wheel drives in Q2.14.
// The light position sits in two registers on the APB port (light_x at 0,
// light_y at 4); write them only while the block is idle.
// A tick that lands in a fixed-drive mode goes from S_IDLE to S_OUT and
// then into the output register. A seek tick runs the iterative CORDIC,
// one step per cycle through a single shifter/adder set, then a shared
// multiplier, and scales both drives down in S_SCL_L and S_SCL_R when the
// light is close enough; on the light itself the CORDIC ends at once.
// The block takes one tick at a time; in_ready is high only while the
// sequencer waits for work, so a new tick is taken only after the last one
// has left S_OUT. Reset puts the block in seek mode with the tick timer at
// zero and the light at (0.5, 0.5). A finished result waits in the output
// register while the receiver stalls; the block still accepts the next tick
// meanwhile, but does not finish it until the output register is free.
module reactive_robot_navigation_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrn_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rrn_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rrn_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CORDIC = 3'd1;
  localparam logic [2:0] S_MULT   = 3'd2;
  localparam logic [2:0] S_SCL_L  = 3'd3;
  localparam logic [2:0] S_SCL_R  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam logic signed [DRV_W-1:0]   KSCALE    = DRV_W'(TH_03);
  localparam logic signed [DRV_W-1:0]   SEEK_BASE = DRV_W'(TH_07);
  localparam logic signed [2*DRV_W-1:0] RND_T     = (2*DRV_W)'(16384);
  localparam logic signed [2*DRV_W-1:0] RND_S     = (2*DRV_W)'(8192);

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [14:0]             light_x;
  logic [14:0]             light_y;
  logic [2:0]              nav_mode;
  logic [7:0]              mode_ticks;
  logic [15:0]             heading;
  logic                    near_light;
  logic signed [15:0]      err;
  logic signed [DRV_W-1:0] wl;
  logic signed [DRV_W-1:0] wr;
  logic                    in_fire;
  logic                    out_free;
  mode_upd_t               upd;
  logic signed [DXY_W-1:0] dx;
  logic signed [DXY_W-1:0] dy;
  logic                    cordic_start;
  logic                    cordic_busy;
  logic                    cordic_done;
  logic [15:0]             cordic_angle;
  logic signed [DRV_W-1:0]   mul_a;
  logic signed [2*DRV_W-1:0] prod;
  logic signed [2*DRV_W-1:0] rnd;
  logic signed [DRV_W-1:0]   mul_res;

  function automatic logic signed [15:0] clamp_q(input logic signed [DRV_W-1:0] v);
    logic signed [15:0] r;
    if (v > DRV_W'(ONE_Q)) begin
      r = ONE_Q;
    end else if (v < -DRV_W'(ONE_Q)) begin
      r = -ONE_Q;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {17'b0, light_y} : {17'b0, light_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= 15'd8192;
      light_y <= 15'd8192;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        light_y <= pwdata[14:0];
      end else begin
        light_x <= pwdata[14:0];
      end
    end
  end

  // Mode transitions and fixed drives.
  rrn_mode u_mode (
    .nav_mode   (nav_mode),
    .mode_ticks (mode_ticks),
    .sl         (in_item.range_left),
    .sm         (in_item.range_mid),
    .sr         (in_item.range_right),
    .upd        (upd)
  );

  // Angle to the light.
  assign dx = DXY_W'({1'b0, light_x}) - DXY_W'(in_item.pos_x);
  assign dy = DXY_W'({1'b0, light_y}) - DXY_W'(in_item.pos_y);
  assign cordic_start = in_fire && upd.seek;

  rrn_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .dx    (dx),
    .dy    (dy),
    .busy  (cordic_busy),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  // Shared multiplier: steering gain on the error, then the near-light scaling.
  always_comb begin
    unique case (state)
      S_SCL_L: mul_a = wl;
      S_SCL_R: mul_a = wr;
      default: mul_a = DRV_W'(err);
    endcase
  end

  assign prod    = (2*DRV_W)'(mul_a) * (2*DRV_W)'(KSCALE);
  assign rnd     = prod + ((state == S_MULT) ? RND_T : RND_S);
  assign mul_res = (state == S_MULT) ? DRV_W'(rnd >>> 15) : DRV_W'(rnd >>> 14);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = upd.seek ? S_CORDIC : S_OUT;
        end
      end
      S_CORDIC: begin
        if (cordic_done) begin
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        state_next = near_light ? S_SCL_L : S_OUT;
      end
      S_SCL_L: begin
        state_next = S_SCL_R;
      end
      S_SCL_R: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nav_mode   <= MODE_SEEK;
      mode_ticks <= 8'd0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        nav_mode   <= upd.mode;
        mode_ticks <= upd.ticks;
      end
    end
  end

  // Datapath registers of the tick at work.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      heading    <= in_item.heading_angle;
      near_light <= (in_item.light_level < TH_005);
      wl         <= upd.wl;
      wr         <= upd.wr;
    end
    if (state == S_CORDIC && cordic_done) begin
      err <= $signed(cordic_angle - heading);
    end
    if (state == S_MULT) begin
      wl <= SEEK_BASE + mul_res;
      wr <= SEEK_BASE - mul_res;
    end
    if (state == S_SCL_L) begin
      wl <= mul_res;
    end
    if (state == S_SCL_R) begin
      wr <= mul_res;
    end
  end

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_item.wheel_left  <= clamp_q(wl);
      out_item.wheel_right <= clamp_q(wr);
      out_item.mode        <= nav_mode;
    end
  end

  // The mode register never leaves the six defined modes.
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    nav_mode <= MODE_FOLLOW_R)
    else $error("navigation mode out of range");

  // A mode change always restarts the tick timer.
  a_timer_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && upd.mode != nav_mode |=> mode_ticks == 8'd0)
    else $error("tick timer not cleared on mode change");

  // The CORDIC unit only runs while the sequencer waits for it.
  a_cordic_owned: assert property (@(posedge clk) disable iff (rst)
    cordic_busy |-> state == S_CORDIC)
    else $error("CORDIC busy outside its sequencer state");

  // Presented wheel drives stay within [-1, 1].
  a_drive_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.wheel_left <= ONE_Q && out_item.wheel_left >= -ONE_Q
      && out_item.wheel_right <= ONE_Q && out_item.wheel_right >= -ONE_Q)
    else $error("wheel drive outside clamp range");

endmodule
